@@ hw/rtl/stpf_pkg.sv @@
package stpf_pkg;

    // Field widths fixed by the interface.
    localparam int MAG_W      = 24;
    localparam int SLOPE_W    = 25;
    localparam int BASE_W     = 10;
    localparam int BIN_OUT_W  = 11;
    localparam int COUNT_W    = 10;
    localparam int SLOT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // Widest peak position over the supported frame lengths (up to 4096 bins).
    localparam int POS_MAX_W  = 12;

    // Signed width that holds a doubled derivative and the drop between two of them.
    localparam int DIFF_W     = 27;

    // The peak counter saturates here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    // Configuration register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMP_THRESHOLD   = 2'd0,
        CFG_SLOPE_THRESHOLD = 2'd1,
        CFG_BASE_BIN        = 2'd2
    } t_cfg_reg;

    // Peak candidate handed from the crossing detector to the ranking logic.
    typedef struct packed {
        logic                 found;
        logic [POS_MAX_W-1:0] pos;
        logic [MAG_W-1:0]     mag;
    } t_peak_cand;

endpackage

@@ hw/rtl/stpf_detect.sv @@
module stpf_detect #(
    parameter int MAX_BINS = 1024
) (
    input  logic [stpf_pkg::MAG_W-1:0]       i_mag,
    input  logic [stpf_pkg::MAG_W-1:0]       i_prev0,
    input  logic [stpf_pkg::MAG_W-1:0]       i_prev1,
    input  logic [stpf_pkg::MAG_W-1:0]       i_prev2,
    input  logic [$clog2(MAX_BINS+1)-1:0]    i_bin_pos,
    input  logic [stpf_pkg::SLOPE_W-1:0]     i_slope_threshold,
    input  logic [stpf_pkg::MAG_W-1:0]       i_amp_threshold,
    output stpf_pkg::t_peak_cand             o_cand
);
    import stpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_BINS + 1);

    logic signed [DIFF_W-1:0] w_m0;
    logic signed [DIFF_W-1:0] w_m1;
    logic signed [DIFF_W-1:0] w_m2;
    logic signed [DIFF_W-1:0] w_m3;
    logic signed [DIFF_W-1:0] w_dj;
    logic signed [DIFF_W-1:0] w_dn;
    logic signed [DIFF_W-1:0] w_drop;
    logic signed [DIFF_W-1:0] w_slope;
    logic                     w_first;
    logic                     w_in_range;
    logic                     w_cross;
    logic                     w_upper;
    logic [POS_MAX_W-1:0]     w_pos_j;

    // Zero-extend the magnitudes so that differences cannot wrap.
    assign w_m0    = $signed({{(DIFF_W - MAG_W){1'b0}}, i_mag});
    assign w_m1    = $signed({{(DIFF_W - MAG_W){1'b0}}, i_prev0});
    assign w_m2    = $signed({{(DIFF_W - MAG_W){1'b0}}, i_prev1});
    assign w_m3    = $signed({{(DIFF_W - MAG_W){1'b0}}, i_prev2});
    assign w_slope = $signed({{(DIFF_W - SLOPE_W){1'b0}}, i_slope_threshold});

    // Doubled derivative at the candidate bin and at the bin after it. The first bin
    // of a frame has no left neighbor and uses twice its forward difference.
    assign w_first = (i_bin_pos == CNT_W'(2));
    assign w_dj    = w_first ? ((w_m1 - w_m2) <<< 1) : (w_m1 - w_m3);
    assign w_dn    = w_m0 - w_m2;
    assign w_drop  = w_dj - w_dn;

    // A falling zero crossing steep enough to pass the slope threshold.
    assign w_in_range = (i_bin_pos >= CNT_W'(2)) && (i_bin_pos < CNT_W'(MAX_BINS));
    assign w_cross    = w_in_range && !w_dj[DIFF_W-1]
                      && (w_dn[DIFF_W-1] || (w_dn == '0))
                      && (w_dj != w_dn) && (w_drop > w_slope);

    // The larger of the two straddling bins is the peak; a tie takes the lower bin.
    assign w_pos_j = POS_MAX_W'(i_bin_pos - CNT_W'(2));
    assign w_upper = (i_prev0 > i_prev1);

    assign o_cand.pos   = w_upper ? (w_pos_j + POS_MAX_W'(1)) : w_pos_j;
    assign o_cand.mag   = w_upper ? i_prev0 : i_prev1;
    assign o_cand.found = w_cross && (o_cand.mag >= i_amp_threshold);

endmodule

@@ hw/rtl/spectrum_top_peak_finder_core.sv @@
// Spectrum top-peak finder. One bin magnitude is taken per clock cycle; the bin flagged
// with frame_end closes the frame. Each bin is first captured in an input register and
// processed from it once taken; the slope-crossing test and the insertion into the
// ranked peak list finish in one pass. The closing bin copies the list into a report
// buffer, and the report goes out as PEAK_SLOTS transfers, largest peak first, starting
// the cycle after the closing bin is processed. Bins of the next frame keep flowing at one
// per cycle while the report drains; input stalls only when a second frame end arrives
// while the previous report still has transfers left, so a frame of at least PEAK_SLOTS
// bins never stalls on an unstalled output. Bins at position MAX_BINS or beyond are
// ignored except for their frame_end flag. Configuration writes are always ready and
// should be made while no frame is in progress.
module spectrum_top_peak_finder_core #(
    parameter int PEAK_SLOTS = 3,
    parameter int MAX_BINS   = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [stpf_pkg::MAG_W-1:0]         i_magnitude,
    input  logic                               i_frame_end,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [stpf_pkg::SLOT_W-1:0]        o_slot,
    output logic [stpf_pkg::BIN_OUT_W-1:0]     o_peak_bin,
    output logic [stpf_pkg::MAG_W-1:0]         o_peak_magnitude,
    output logic                               o_slot_valid,
    output logic [stpf_pkg::COUNT_W-1:0]       o_peak_count,
    output logic                               o_run_end,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stpf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stpf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import stpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int POS_W = $clog2(MAX_BINS);
    localparam int IDX_W = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
    localparam int SUM_W = ((POS_W > BASE_W) ? POS_W : BASE_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PEAK_SLOTS - 1);

    // Configuration registers.
    logic [MAG_W-1:0]   r_amp_threshold;
    logic [SLOPE_W-1:0] r_slope_threshold;
    logic [BASE_W-1:0]  r_base_bin;

    // Input register.
    logic               r_in_valid;
    logic [MAG_W-1:0]   r_in_mag;
    logic               r_in_last;

    // Frame state.
    logic [MAG_W-1:0]   r_recent [3];
    logic [CNT_W-1:0]   r_bin_pos;
    logic [COUNT_W-1:0] r_count;
    logic [POS_W-1:0]   r_top_bin [PEAK_SLOTS];
    logic [MAG_W-1:0]   r_top_mag [PEAK_SLOTS];

    // Report buffer.
    logic                  r_rep_busy;
    logic [IDX_W-1:0]      r_rep_idx;
    logic [BIN_OUT_W-1:0]  r_rep_bin   [PEAK_SLOTS];
    logic [MAG_W-1:0]      r_rep_mag   [PEAK_SLOTS];
    logic [PEAK_SLOTS-1:0] r_rep_valid;
    logic [COUNT_W-1:0]    r_rep_count;

    // Next values of the ranked list.
    logic [POS_W-1:0]   n_top_bin [PEAK_SLOTS];
    logic [MAG_W-1:0]   n_top_mag [PEAK_SLOTS];
    logic [COUNT_W-1:0] n_count;

    t_peak_cand            w_cand;
    logic [PEAK_SLOTS-1:0] w_hit;
    logic [PEAK_SLOTS-1:0] w_before;
    logic                  w_in_xfer;
    logic                  w_out_xfer;
    logic                  w_rep_free;
    logic                  w_take;
    logic                  w_in_range;

    // Handshake control.
    assign o_cfg_ready = 1'b1;
    assign w_out_xfer  = o_out_valid && !i_out_stall;
    assign w_rep_free  = !r_rep_busy || ((r_rep_idx == LAST_IDX) && w_out_xfer);
    assign w_take      = r_in_valid && (!r_in_last || w_rep_free);
    assign o_in_stall  = r_in_valid && !w_take;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_in_range  = (r_bin_pos < CNT_W'(MAX_BINS));

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_threshold   <= '0;
            r_slope_threshold <= '0;
            r_base_bin        <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_AMP_THRESHOLD:   r_amp_threshold   <= i_cfg_data[MAG_W-1:0];
                CFG_SLOPE_THRESHOLD: r_slope_threshold <= i_cfg_data[SLOPE_W-1:0];
                CFG_BASE_BIN:        r_base_bin        <= i_cfg_data[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_mag  <= i_magnitude;
            r_in_last <= i_frame_end;
        end
    end

    // Slope-crossing detection on the registered bin and the three before it.
    stpf_detect #(
        .MAX_BINS (MAX_BINS)
    ) u_detect (
        .i_mag             (r_in_mag),
        .i_prev0           (r_recent[0]),
        .i_prev1           (r_recent[1]),
        .i_prev2           (r_recent[2]),
        .i_bin_pos         (r_bin_pos),
        .i_slope_threshold (r_slope_threshold),
        .i_amp_threshold   (r_amp_threshold),
        .o_cand            (w_cand)
    );

    // A slot takes the new peak if it is empty or holds a smaller one.
    always_comb begin
        for (int i = 0; i < PEAK_SLOTS; i++) begin
            w_hit[i] = (COUNT_W'(i) >= r_count) || (w_cand.mag > r_top_mag[i]);
        end
    end

    always_comb begin
        w_before[0] = 1'b0;
        for (int i = 1; i < PEAK_SLOTS; i++) begin
            w_before[i] = w_before[i-1] || w_hit[i-1];
        end
    end

    // Ranked insertion: slots below the insertion point shift down by one.
    always_comb begin
        for (int a = 0; a < PEAK_SLOTS; a++) begin
            n_top_bin[a] = r_top_bin[a];
            n_top_mag[a] = r_top_mag[a];
            if (w_cand.found) begin
                if (w_before[a]) begin
                    n_top_bin[a] = r_top_bin[(a == 0) ? 0 : a - 1];
                    n_top_mag[a] = r_top_mag[(a == 0) ? 0 : a - 1];
                end else if (w_hit[a]) begin
                    n_top_bin[a] = POS_W'(w_cand.pos);
                    n_top_mag[a] = w_cand.mag;
                end
            end
        end
        n_count = r_count;
        if (w_cand.found && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    // Frame control state; a closing bin restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_pos <= '0;
            r_count   <= '0;
        end else if (w_take) begin
            if (r_in_last) begin
                r_bin_pos <= '0;
                r_count   <= '0;
            end else begin
                r_count <= n_count;
                if (w_in_range) begin
                    r_bin_pos <= r_bin_pos + CNT_W'(1);
                end
            end
        end
    end

    // Recent magnitudes and the ranked list; the count alone marks which slots hold data.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (w_in_range) begin
                r_recent[2] <= r_recent[1];
                r_recent[1] <= r_recent[0];
                r_recent[0] <= r_in_mag;
            end
            for (int a = 0; a < PEAK_SLOTS; a++) begin
                r_top_bin[a] <= n_top_bin[a];
                r_top_mag[a] <= n_top_mag[a];
            end
        end
    end

    // Report sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_busy <= 1'b0;
            r_rep_idx  <= '0;
        end else if (w_take && r_in_last) begin
            r_rep_busy <= 1'b1;
            r_rep_idx  <= '0;
        end else if (w_out_xfer) begin
            if (r_rep_idx == LAST_IDX) begin
                r_rep_busy <= 1'b0;
                r_rep_idx  <= '0;
            end else begin
                r_rep_idx <= r_rep_idx + IDX_W'(1);
            end
        end
    end

    // Report buffer load with the list as it stands after the closing bin.
    always_ff @(posedge i_clk) begin
        if (w_take && r_in_last) begin
            r_rep_count <= n_count;
            for (int i = 0; i < PEAK_SLOTS; i++) begin
                r_rep_valid[i] <= (COUNT_W'(i) < n_count);
                if (COUNT_W'(i) < n_count) begin
                    r_rep_bin[i] <= BIN_OUT_W'(SUM_W'(r_base_bin) + SUM_W'(n_top_bin[i]));
                    r_rep_mag[i] <= n_top_mag[i];
                end else begin
                    r_rep_bin[i] <= BIN_OUT_W'(r_base_bin);
                    r_rep_mag[i] <= '0;
                end
            end
        end
    end

    // Result fields.
    assign o_out_valid      = r_rep_busy;
    assign o_slot           = SLOT_W'(r_rep_idx);
    assign o_peak_bin       = r_rep_bin[r_rep_idx];
    assign o_peak_magnitude = r_rep_mag[r_rep_idx];
    assign o_slot_valid     = r_rep_valid[r_rep_idx];
    assign o_peak_count     = r_rep_count;
    assign o_run_end        = (r_rep_idx == LAST_IDX);

    // A filled slot is always within the reported count.
    a_slot_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_slot_valid) |-> (o_peak_count > COUNT_W'(r_rep_idx)))
        else $error("filled slot beyond peak count");

    // Once a report starts it continues until its last slot.
    a_report_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && !o_run_end) |=> o_out_valid)
        else $error("report broke off before its last slot");

    // Slots within one report come out in non-increasing magnitude.
    a_report_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && !o_run_end) |=> (o_peak_magnitude <= $past(o_peak_magnitude)))
        else $error("report slots out of order");

    // Input only stalls on a frame end that waits for the report buffer.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_last && r_rep_busy))
        else $error("input stalled without a pending report");

    // The bin position never runs past the frame limit.
    a_bin_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin_pos <= CNT_W'(MAX_BINS))
        else $error("bin position beyond frame limit");

endmodule

@@ dv/tb.sv @@
module tb;
    import stpf_pkg::*;

    localparam int NUM_SLOTS     = 3;
    localparam int FRAME_BINS    = 1024;
    localparam int IDLE_PCT      = 9;
    localparam int SETTLE_CYCLES = 6;
    localparam int DIR_ROWS      = 30;
    localparam int PHASES        = 7;
    localparam int PHASE_BINS    = 18;
    localparam int MAX_SHOWN     = 10;

    // Register index outside the map; writes to it must leave every register untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        ROW_BIN,
        ROW_CFG
    } t_row_kind;

    // One line of the directed stimulus table.
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        logic                   last;
        logic                   typed;
        logic [COUNT_W-1:0]     t_cnt;
        logic [BIN_OUT_W-1:0]   t_bin;
        logic [MAG_W-1:0]       t_mag;
    } t_row;

    // One slot of a frame report.
    typedef struct packed {
        logic [SLOT_W-1:0]      slot;
        logic [BIN_OUT_W-1:0]   bin;
        logic [MAG_W-1:0]       mag;
        logic                   used;
        logic [COUNT_W-1:0]     count;
        logic                   last;
    } t_slot_report;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [MAG_W-1:0]       i_magnitude;
    logic                   i_frame_end;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [SLOT_W-1:0]      o_slot;
    logic [BIN_OUT_W-1:0]   o_peak_bin;
    logic [MAG_W-1:0]       o_peak_magnitude;
    logic                   o_slot_valid;
    logic [COUNT_W-1:0]     o_peak_count;
    logic                   o_run_end;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Predicted register contents and frame state.
    logic [MAG_W-1:0]       amp_thr;
    logic [SLOPE_W-1:0]     slope_thr;
    logic [BASE_W-1:0]      bin_base;
    logic [MAG_W-1:0]       hist [3];
    logic [BIN_OUT_W-1:0]   bins_taken;
    logic [BASE_W-1:0]      rank_bin [NUM_SLOTS];
    logic [MAG_W-1:0]       rank_mag [NUM_SLOTS];
    logic [COUNT_W-1:0]     peaks_found;

    t_slot_report           pending_slots [$];
    int                     mismatches;
    logic                   calm;

    spectrum_top_peak_finder_core #(
        .PEAK_SLOTS (NUM_SLOTS),
        .MAX_BINS   (FRAME_BINS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_magnitude      (i_magnitude),
        .i_frame_end      (i_frame_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_slot           (o_slot),
        .o_peak_bin       (o_peak_bin),
        .o_peak_magnitude (o_peak_magnitude),
        .o_slot_valid     (o_slot_valid),
        .o_peak_count     (o_peak_count),
        .o_run_end        (o_run_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random gaps on either side, suppressed during the calm stretch.
    function automatic logic take_break();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic void clear_frame();
        for (int i = 0; i < 3; i++) hist[i] = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            rank_bin[i] = '0;
            rank_mag[i] = '0;
        end
        bins_taken  = '0;
        peaks_found = '0;
    endfunction

    // Insert a peak into the ranked list; equal magnitudes go behind the held entry.
    function automatic void rank_peak(logic [BASE_W-1:0] pos, logic [MAG_W-1:0] mag);
        logic placed;
        placed = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!placed && i >= peaks_found) begin
                rank_bin[i] = pos;
                rank_mag[i] = mag;
                placed = 1'b1;
            end else if (!placed && mag > rank_mag[i]) begin
                for (int a = NUM_SLOTS - 1; a > i; a--) begin
                    rank_bin[a] = rank_bin[a - 1];
                    rank_mag[a] = rank_mag[a - 1];
                end
                rank_bin[i] = pos;
                rank_mag[i] = mag;
                placed = 1'b1;
            end
        end
        if (peaks_found < COUNT_MAX) peaks_found++;
    endfunction

    // Advance the frame state by one bin and queue the report on a frame end.
    function automatic void track_bin(logic [MAG_W-1:0] mag, logic last);
        logic signed [DIFF_W-1:0] m_cur, m_b1, m_b2, m_b3, d_here, d_next;
        logic [BASE_W-1:0]        j, pk_pos;
        logic [MAG_W-1:0]         pk_mag;
        t_slot_report             r;
        if (bins_taken < FRAME_BINS) begin
            if (bins_taken >= 2) begin
                m_cur  = $signed({3'b000, mag});
                m_b1   = $signed({3'b000, hist[0]});
                m_b2   = $signed({3'b000, hist[1]});
                m_b3   = $signed({3'b000, hist[2]});
                j      = BASE_W'(bins_taken - 2);
                d_here = (j == 0) ? 2 * (m_b1 - m_b2) : (m_b1 - m_b3);
                d_next = m_cur - m_b2;
                if (d_here >= 0 && d_next <= 0 && d_here != d_next &&
                        (d_here - d_next) > $signed({2'b00, slope_thr})) begin
                    // The larger of the two straddling bins is the peak; a tie keeps the lower.
                    pk_pos = j;
                    pk_mag = hist[1];
                    if (hist[0] > hist[1]) begin
                        pk_pos = j + 1'b1;
                        pk_mag = hist[0];
                    end
                    if (pk_mag >= amp_thr) rank_peak(pk_pos, pk_mag);
                end
            end
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = mag;
            bins_taken++;
        end
        if (last) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r.slot  = SLOT_W'(i);
                r.used  = (i < peaks_found);
                r.bin   = r.used ? {1'b0, bin_base} + {1'b0, rank_bin[i]} : {1'b0, bin_base};
                r.mag   = r.used ? rank_mag[i] : '0;
                r.count = peaks_found;
                r.last  = (i == NUM_SLOTS - 1);
                pending_slots.push_back(r);
            end
            clear_frame();
        end
    endfunction

    function automatic logic [MAG_W-1:0] pick_mag();
        if ($urandom_range(0, 9) < 3) return MAG_W'($urandom);
        return MAG_W'($urandom_range(0, 100));
    endfunction

    function automatic t_row bin_row(logic [MAG_W-1:0] mag, logic last);
        t_row r;
        r       = '0;
        r.kind  = ROW_BIN;
        r.val   = {1'b0, mag};
        r.last  = last;
        return r;
    endfunction

    // Closing bin whose slot 0 result is written out by hand.
    function automatic t_row chk_row(logic [MAG_W-1:0] mag, logic [COUNT_W-1:0] cnt,
                                     logic [BIN_OUT_W-1:0] pbin, logic [MAG_W-1:0] pmag);
        t_row r;
        r       = bin_row(mag, 1'b1);
        r.typed = 1'b1;
        r.t_cnt = cnt;
        r.t_bin = pbin;
        r.t_mag = pmag;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = data;
        return r;
    endfunction

    // Directed stimulus table.
    function automatic t_row dir_row(int n);
        case (n)
            // A one-bin and a two-bin frame are too short to hold a peak.
            0:  return chk_row(24'hFFFFFF, 10'd0, 11'd0, 24'd0);
            1:  return bin_row(24'd5, 1'b0);
            2:  return chk_row(24'd9, 10'd0, 11'd0, 24'd0);
            // Full-scale spike straddled by zeros, detected on the closing bin.
            3:  return bin_row(24'd0, 1'b0);
            4:  return bin_row(24'hFFFFFF, 1'b0);
            5:  return chk_row(24'd0, 10'd1, 11'd1, 24'hFFFFFF);
            // Tied first bins, then more peaks than slots with equal magnitudes.
            6:  return bin_row(24'd4, 1'b0);
            7:  return bin_row(24'd4, 1'b0);
            8:  return bin_row(24'd0, 1'b0);
            9:  return bin_row(24'd9, 1'b0);
            10: return bin_row(24'd0, 1'b0);
            11: return bin_row(24'd0, 1'b0);
            12: return bin_row(24'd9, 1'b0);
            13: return bin_row(24'd0, 1'b0);
            14: return bin_row(24'd2, 1'b0);
            15: return bin_row(24'd0, 1'b1);
            // Flat frame: the derivatives are equal, so no crossing.
            16: return bin_row(24'd3, 1'b0);
            17: return bin_row(24'd3, 1'b0);
            18: return bin_row(24'd3, 1'b1);
            // Top thresholds and offset; the unmapped index must be ignored.
            19: return cfg_row(CFG_AMP_THRESHOLD, 25'hFFFFFF);
            20: return cfg_row(CFG_SLOPE_THRESHOLD, 25'h1FFFFFF);
            21: return cfg_row(CFG_BASE_BIN, 25'h3FF);
            22: return cfg_row(CFG_UNUSED, 25'h1FFFFFF);
            // The largest possible drop does not exceed the top slope threshold.
            23: return bin_row(24'd0, 1'b0);
            24: return bin_row(24'hFFFFFF, 1'b0);
            25: return chk_row(24'd0, 10'd0, 11'h3FF, 24'd0);
            // With the slope threshold open, the full-scale peak meets the top amplitude.
            26: return cfg_row(CFG_SLOPE_THRESHOLD, 25'd0);
            27: return bin_row(24'd0, 1'b0);
            28: return bin_row(24'hFFFFFF, 1'b0);
            29: return chk_row(24'd0, 10'd1, 11'h400, 24'hFFFFFF);
            default: return bin_row(24'd0, 1'b0);
        endcase
    endfunction

    // Offer one bin until the transfer happens; returns on the next falling edge.
    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_magnitude <= mag;
        i_frame_end <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_bin(mag, last);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_AMP_THRESHOLD:   amp_thr   = data[MAG_W-1:0];
            CFG_SLOPE_THRESHOLD: slope_thr = data[SLOPE_W-1:0];
            CFG_BASE_BIN:        bin_base  = data[BASE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop sending, wait for every queued report slot, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_slots.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Output stall, changed on the falling edge.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= take_break();
        end
    end

    // Compare each report transfer with the oldest predicted slot.
    always @(posedge i_clk) begin : check_slots
        t_slot_report want, got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.slot  = o_slot;
            got.bin   = o_peak_bin;
            got.mag   = o_peak_magnitude;
            got.used  = o_slot_valid;
            got.count = o_peak_count;
            got.last  = o_run_end;
            if (pending_slots.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected report: slot %0d bin %0d mag %0d used %0b count %0d end %0b",
                             got.slot, got.bin, got.mag, got.used, got.count, got.last);
            end else begin
                want = pending_slots.pop_front();
                if (got.slot !== want.slot || got.bin !== want.bin || got.mag !== want.mag ||
                        got.used !== want.used || got.count !== want.count ||
                        got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("report mismatch: expected slot %0d bin %0d mag %0d used %0b count %0d end %0b",
                                 want.slot, want.bin, want.mag, want.used, want.count, want.last);
                        $display("                 actual   slot %0d bin %0d mag %0d used %0b count %0d end %0b",
                                 got.slot, got.bin, got.mag, got.used, got.count, got.last);
                    end
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_row               row;
        t_slot_report       fix;
        int                 at;
        int                 sent;
        int                 len;
        logic [MAG_W-1:0]   amp;
        logic [SLOPE_W-1:0] slope;
        logic [BASE_W-1:0]  base;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_magnitude <= '0;
        i_frame_end <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        calm        = 1'b0;
        mismatches  = 0;
        amp_thr     = '0;
        slope_thr   = '0;
        bin_base    = '0;
        clear_frame();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table; hand-written expectations replace the predicted slot 0.
        for (int n = 0; n < DIR_ROWS; n++) begin
            row = dir_row(n);
            if (row.kind == ROW_CFG) begin
                drain();
                cfg_write(row.idx, row.val);
            end else begin
                send_bin(row.val[MAG_W-1:0], row.last);
                if (row.typed) begin
                    at        = pending_slots.size() - NUM_SLOTS;
                    fix       = pending_slots[at];
                    fix.count = row.t_cnt;
                    fix.bin   = row.t_bin;
                    fix.mag   = row.t_mag;
                    fix.used  = (row.t_cnt != 0);
                    pending_slots[at] = fix;
                end
            end
        end

        // Random frames under a new register setting per phase; the last two
        // phases run with no random gaps on either side.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            calm  = (p >= PHASES - 2);
            amp   = (p == 1) ? 24'hFFFFFF : (p == 4) ? MAG_W'($urandom) :
                    (p == 0 || p == PHASES - 1) ? '0 : MAG_W'($urandom_range(0, 60));
            slope = (p == 2) ? 25'h1FFFFFF : (p == 4) ? SLOPE_W'($urandom) :
                    (p == 0) ? '0 : SLOPE_W'($urandom_range(0, 80));
            base  = (p == 3) ? 10'h3FF : (p == 0) ? '0 : BASE_W'($urandom);
            cfg_write(CFG_AMP_THRESHOLD, {1'b0, amp});
            cfg_write(CFG_SLOPE_THRESHOLD, slope);
            cfg_write(CFG_BASE_BIN, {15'd0, base});
            if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));

            sent = 0;
            while (sent < PHASE_BINS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 16);
                for (int k = 0; k < len; k++) send_bin(pick_mag(), k == len - 1);
                sent += len;
                // Occasionally hold the sender until the report has drained.
                if ($urandom_range(0, 7) == 0) drain();
            end
        end

        drain();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
